// ===== rtl/core/pfdt_pkg.sv =====
// pfdt_pkg: shared types and constants of the dirty-tile page framebuffer
// no dependencies; imported by every module of the block

package pfdt_pkg;

  // tile geometry and widths fixed by the field formats
  localparam int TILE_BITS   = 8;
  localparam int BIT_SEL_W   = 3;
  localparam int COUNT_W     = 11;
  localparam int JOB_IDX_W   = 14;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;
  localparam logic [7:0] COLUMNS_RESET = 8'd128;
  localparam logic [3:0] PAGES_RESET   = 4'd8;

  // command codes
  localparam logic [1:0] CMD_GET   = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_PAGES   = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic       ink;
  } pfdt_in_t;

  typedef struct packed {
    logic               status;
    logic               pixel_out;
    logic [COUNT_W-1:0] dirty_count;
  } pfdt_out_t;

  typedef enum logic [1:0] {
    JOB_GET,
    JOB_SET,
    JOB_CLEAR,
    JOB_OOB
  } job_kind_t;

  // classified word handed from front to back; index is the tile for
  // pixel jobs and the active tile total for clear
  typedef struct packed {
    job_kind_t              kind;
    logic [JOB_IDX_W-1:0]   index;
    logic [BIT_SEL_W-1:0]   bit_sel;
    logic                   value;
  } pfdt_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MODIFY,
    BK_SWEEP,
    BK_REPLY
  } back_state_t;

endpackage

// ===== rtl/core/pfdt_front.sv =====
// pfdt_front: geometry registers and classification of incoming words
// depends on pfdt_pkg; feeds pfdt_queue

module pfdt_front import pfdt_pkg::*; #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_PAGES   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pfdt_in_t  in_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [7:0] cfg_data,
  input  logic      q_full,
  input  logic      init_done,
  output logic      push,
  output pfdt_job_t push_job
);

  logic [7:0] columns_r;
  logic [3:0] pages_r;
  logic [8:0] act_cols;
  logic [3:0] act_pages;
  logic [4:0] page;
  logic       is_clear;
  logic       oob;
  logic [4:0] mul_a;
  logic [JOB_IDX_W-1:0] prod;

  // geometry registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RESET;
      pages_r   <= PAGES_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COLUMNS: columns_r <= cfg_data;
        REG_PAGES:   pages_r   <= cfg_data[3:0];
        default:     columns_r <= columns_r;
      endcase
    end
  end

  // geometry limited to the store size
  assign act_cols  = ({1'b0, columns_r} > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS)
                                                           : {1'b0, columns_r};
  assign act_pages = ({2'b00, pages_r} > 6'(MAX_PAGES)) ? 4'(MAX_PAGES) : pages_r;

  assign page     = in_data.y[7:3];
  assign is_clear = (in_data.cmd == CMD_CLEAR);
  assign oob      = ({1'b0, in_data.x} >= act_cols) || (page >= {1'b0, act_pages});

  // one shared multiplier: page * columns for pixels, pages * columns for clear
  assign mul_a = is_clear ? {1'b0, act_pages} : page;
  assign prod  = JOB_IDX_W'(mul_a) * JOB_IDX_W'(act_cols);

  // classify and hand over to the queue
  always_comb begin
    push_job.bit_sel = in_data.y[BIT_SEL_W-1:0];
    push_job.value   = in_data.ink;
    push_job.index   = is_clear ? prod : prod + JOB_IDX_W'(in_data.x);
    priority if (is_clear)              push_job.kind = JOB_CLEAR;
    else if (oob)                       push_job.kind = JOB_OOB;
    else if (in_data.cmd == CMD_SET)    push_job.kind = JOB_SET;
    else                                push_job.kind = JOB_GET;
  end

  assign in_ready = !q_full && init_done;
  assign push     = in_valid && in_ready;

endmodule

// ===== rtl/core/pfdt_queue.sv =====
// pfdt_queue: short first-in first-out queue of classified jobs
// depends on pfdt_pkg; sits between pfdt_front and pfdt_back

module pfdt_queue import pfdt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pfdt_job_t push_job,
  input  logic      pop,
  output pfdt_job_t head,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pfdt_job_t          slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/core/pfdt_back.sv =====
// pfdt_back: tile memory with dirty bits, read-modify-write and clear sweep
// depends on pfdt_pkg; drains pfdt_queue and drives the result register

module pfdt_back import pfdt_pkg::*; #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_PAGES   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  pfdt_job_t head,
  input  logic      empty,
  output logic      pop,
  output logic      init_done,
  output logic      out_valid,
  input  logic      out_ready,
  output pfdt_out_t out_data
);

  localparam int DEPTH = MAX_COLUMNS * MAX_PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = TILE_BITS + 1;

  // each word holds the dirty bit above the tile byte
  logic [WW-1:0]        mem_r [DEPTH];
  logic [WW-1:0]        rd_data_r;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WW-1:0]        wr_data;

  back_state_t          state_r, state_nxt;
  pfdt_job_t            job_r, job_nxt;
  logic [AW-1:0]        sweep_idx_r, sweep_idx_nxt;
  logic [JOB_IDX_W-1:0] sweep_total_r, sweep_total_nxt;
  logic                 sweep_reply_r, sweep_reply_nxt;
  logic                 init_done_r, init_done_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pfdt_out_t            out_data_r, out_data_nxt;
  logic                 out_free;

  logic [TILE_BITS-1:0] tile_cur;
  logic [TILE_BITS-1:0] tile_mod;
  logic                 dirty_cur;
  logic                 pix_cur;
  logic                 change;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign init_done = init_done_r;

  assign tile_cur  = rd_data_r[TILE_BITS-1:0];
  assign dirty_cur = rd_data_r[TILE_BITS];
  assign pix_cur   = tile_cur[job_r.bit_sel];
  assign change    = (job_r.kind == JOB_SET) && (pix_cur != job_r.value);

  // tile memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // sequencer: pop, read-modify-write, clear sweep, reply
  always_comb begin
    state_nxt       = state_r;
    job_nxt         = job_r;
    sweep_idx_nxt   = sweep_idx_r;
    sweep_total_nxt = sweep_total_r;
    sweep_reply_nxt = sweep_reply_r;
    init_done_nxt   = init_done_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    pop             = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = head.index[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = sweep_idx_r;
    wr_data         = {(JOB_IDX_W'(sweep_idx_r) < sweep_total_r), {TILE_BITS{1'b0}}};
    tile_mod        = tile_cur;

    unique case (state_r)
      BK_IDLE: begin
        if (!empty) begin
          pop     = 1'b1;
          job_nxt = head;
          if (head.kind == JOB_CLEAR) begin
            sweep_total_nxt = head.index;
            sweep_reply_nxt = 1'b1;
            sweep_idx_nxt   = '0;
            count_nxt       = (head.index > JOB_IDX_W'(COUNT_MAX)) ? COUNT_MAX
                                                                 : head.index[COUNT_W-1:0];
            state_nxt       = BK_SWEEP;
          end else begin
            rd_en     = 1'b1;
            state_nxt = BK_MODIFY;
          end
        end
      end

      BK_MODIFY: begin
        if (out_free) begin
          tile_mod[job_r.bit_sel] = job_r.value;
          wr_en   = change;
          wr_addr = job_r.index[AW-1:0];
          wr_data = {1'b1, tile_mod};
          if (change && !dirty_cur && (count_r != COUNT_MAX)) begin
            count_nxt = count_r + 1'b1;
          end
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = (job_r.kind == JOB_OOB);
          out_data_nxt.pixel_out = (job_r.kind == JOB_OOB) ? 1'b0
                                   : (change ? job_r.value : pix_cur);
          out_data_nxt.dirty_count = count_nxt;
          state_nxt = BK_IDLE;
        end
      end

      BK_SWEEP: begin
        wr_en = 1'b1;
        if (sweep_idx_r == AW'(DEPTH - 1)) begin
          init_done_nxt = 1'b1;
          state_nxt     = sweep_reply_r ? BK_REPLY : BK_IDLE;
        end else begin
          sweep_idx_nxt = sweep_idx_r + 1'b1;
        end
      end

      BK_REPLY: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = 1'b0;
          out_data_nxt.pixel_out   = 1'b0;
          out_data_nxt.dirty_count = count_r;
          sweep_reply_nxt          = 1'b0;
          state_nxt                = BK_IDLE;
        end
      end

      default: state_nxt = BK_IDLE;
    endcase
  end

  // control state; the sweep after reset clears the whole store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_SWEEP;
      sweep_idx_r   <= '0;
      sweep_total_r <= '0;
      sweep_reply_r <= 1'b0;
      init_done_r   <= 1'b0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sweep_idx_r   <= sweep_idx_nxt;
      sweep_total_r <= sweep_total_nxt;
      sweep_reply_r <= sweep_reply_nxt;
      init_done_r   <= init_done_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/core/page_framebuffer_dirty_tiles.sv =====
// page_framebuffer_dirty_tiles: top level of the dirty-tile page framebuffer
// depends on pfdt_pkg, pfdt_front, pfdt_queue and pfdt_back

// One-bit-per-pixel display store of MAX_COLUMNS x MAX_PAGES byte tiles with a
// dirty bit per tile and a saturating dirty count. Each input word (get, set or
// clear) gives one result word. The front classifies a word in the cycle it is
// accepted and places it in a two-entry queue; the back takes a get or set
// through a read of one memory word, and a set that changes the pixel writes
// it back; it finishes one job before it takes the next. A clear sweeps the
// memory one word a cycle. After reset the same sweep runs over all
// MAX_COLUMNS * MAX_PAGES words before in_ready rises; configuration writes
// are taken throughout. Geometry writes take effect for the words accepted
// after them.

module page_framebuffer_dirty_tiles import pfdt_pkg::*; #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_PAGES   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  pfdt_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output pfdt_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic      push;
  pfdt_job_t push_job;
  pfdt_job_t head;
  logic      pop;
  logic      q_full;
  logic      q_empty;
  logic      init_done;

  // classification and geometry
  pfdt_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_PAGES   (MAX_PAGES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .init_done (init_done),
    .push      (push),
    .push_job  (push_job)
  );

  // job queue between front and back
  pfdt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // memory, dirty tracking and results
  pfdt_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_PAGES   (MAX_PAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .init_done (init_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
